@@ hw/rtl/slii_pkg.sv @@
package slii_pkg;

    // List capacity and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Request and result codes.
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_READ   = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BEYOND = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Input beat.
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] value;
        logic        [7:0]  position;
    } t_req;

    // Output beat.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic        [1:0]  status;
    } t_rsp;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic               shift;
        logic signed [31:0] value;
    } t_link;

endpackage

@@ hw/rtl/sorted_list_insert_and_index_top.sv @@
// Sorted list with insert and read by rank.
// Input channel (i_in_valid, o_in_stall, i_in_data): each beat is either an
// insert of a signed value or a read at a zero-based position. Output channel
// (o_out_valid, i_out_stall, o_out_data): exactly one beat per input beat, in
// order, carrying the read value and a status (ok, empty, beyond, full).
// The result beat is registered on the accepting edge.
// Throughput is one request per cycle while the receiver does not stall:
// every cell compares its entry with the new value in parallel and shifts
// right in the same cycle, and a read is one select over the cells into the
// output register. An insert into a full list is dropped and reports full; a
// read on an empty list or at a position at or beyond the count returns zero with an error.
// Reset clears the entry count and the output valid; the cells need no
// clearing, since ranks at or beyond the count are never read.
// While the receiver stalls, the result beat holds in the output register and
// o_in_stall is raised, so no new request is taken until the result drains.
module sorted_list_insert_and_index_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  slii_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output slii_pkg::t_rsp  o_out_data
);
    import slii_pkg::*;

    logic               r_out_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;
    logic [COUNT_W-1:0] r_count;
    logic               w_accept;
    logic               w_is_read;
    logic               w_full;
    logic               w_ins_en;
    logic signed [31:0] w_vals [CAPACITY];
    t_link              w_link [CAPACITY+1];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_is_read  = (i_in_data.req_type == REQ_READ);
    assign w_full     = (r_count == COUNT_W'(CAPACITY));
    assign w_ins_en   = w_accept && !w_is_read && !w_full;

    // Chain of cells, each passing its shift flag and entry to the right.
    assign w_link[0] = '{shift: 1'b0, value: '0};

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        slii_cell u_cell (
            .i_clk       (i_clk),
            .i_ins_en    (w_ins_en),
            .i_occupied  (r_count > COUNT_W'(k)),
            .i_at_count  (r_count == COUNT_W'(k)),
            .i_new_value (i_in_data.value),
            .i_left      (w_link[k]),
            .o_link      (w_link[k+1]),
            .o_value     (w_vals[k])
        );
    end

    // Result of the request being accepted.
    always_comb begin
        n_rsp.read_value = '0;
        n_rsp.status     = ST_OK;
        if (!w_is_read) begin
            if (w_full) begin
                n_rsp.status = ST_FULL;
            end
        end else if (r_count == '0) begin
            n_rsp.status = ST_EMPTY;
        end else if ({1'b0, i_in_data.position} >= 9'(r_count)) begin
            n_rsp.status = ST_BEYOND;
        end else begin
            n_rsp.read_value = w_vals[i_in_data.position[IDX_W-1:0]];
        end
    end

    // Entry count, output valid and the registered result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ins_en) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_rsp;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An insert into a list with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_read && !w_full) |=> (r_count == $past(r_count) + COUNT_W'(1)))
        else $error("insert did not grow the count");

    // A read of an empty list reports empty with a zero value.
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_read && r_count == '0) |=>
        (o_out_valid && o_out_data.status == ST_EMPTY && o_out_data.read_value == '0))
        else $error("empty read gave a wrong result");

    // An insert into a full list leaves the count and reports full.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_read && w_full) |=>
        (r_count == COUNT_W'(CAPACITY) && o_out_data.status == ST_FULL))
        else $error("insert into a full list was not dropped");

endmodule

@@ hw/rtl/slii_cell.sv @@
module slii_cell (
    input  logic                i_clk,
    input  logic                i_ins_en,
    input  logic                i_occupied,
    input  logic                i_at_count,
    input  logic signed [31:0]  i_new_value,
    input  slii_pkg::t_link     i_left,
    output slii_pkg::t_link     o_link,
    output logic signed [31:0]  o_value
);
    import slii_pkg::*;

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               w_here_or_right;

    // The new value belongs at or before this cell when this cell holds a
    // value that is greater or equal, or when this is the first free cell.
    assign w_here_or_right = (i_occupied && ($signed(r_value) >= $signed(i_new_value)))
                             || i_at_count;

    // If the left neighbor is also at or after the slot, take its value;
    // the first such cell takes the new value; cells before the slot hold.
    always_comb begin
        n_value = r_value;
        if (i_left.shift) begin
            n_value = i_left.value;
        end else if (w_here_or_right) begin
            n_value = i_new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins_en) begin
            r_value <= n_value;
        end
    end

    assign o_link.shift = w_here_or_right;
    assign o_link.value = r_value;
    assign o_value      = r_value;

endmodule
